// ===== hdl/array_deque_with_reverse_sort_defines.svh =====
// Assertion macros used by adrs_checker.
// Each one checks under a clock and an active-low reset.
`ifndef ARRAY_DEQUE_WITH_REVERSE_SORT_DEFINES_SVH
`define ARRAY_DEQUE_WITH_REVERSE_SORT_DEFINES_SVH

// Same-cycle implication.
`define ADRS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication.
`define ADRS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ===== hdl/adrs_pkg.sv =====
`default_nettype none
package adrs_pkg;

	localparam int DEPTH_DEF   = 128;
	localparam int QUEUE_DEPTH = 4;

	localparam int OPCODE_W = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;

	localparam int S_TDATA_W = VALUE_W;
	localparam int S_TUSER_W = OPCODE_W;
	localparam int M_TDATA_W = 2 * VALUE_W + COUNT_W;
	localparam int M_TUSER_W = STATUS_W + 1;

	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_REVERSE    = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SORT       = 3'd6;

	localparam logic signed [VALUE_W-1:0] EMPTY_WORD = -32'sd1;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT,
		CMD_PUSH_BACK,
		CMD_POP_FRONT,
		CMD_POP_BACK,
		CMD_CLEAR,
		CMD_REVERSE,
		CMD_SORT,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic signed [VALUE_W-1:0]  value;
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_OVERFLOW  = 2'd1,
		STS_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DONE,
		BK_REF_A,
		BK_REF_B,
		BK_REF_C,
		BK_REV_A,
		BK_REV_B,
		BK_REV_C,
		BK_REV_D,
		BK_SRT_LD,
		BK_SRT_GET,
		BK_SRT_CMP,
		BK_SRT_PUT
	} back_state_t;

endpackage
`default_nettype wire

// ===== hdl/adrs_ram.sv =====
`default_nettype none
module adrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/adrs_fifo.sv =====
`default_nettype none
module adrs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [WIDTH-1:0] out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;
	logic             push;
	logic             pop;

	assign in_ready  = (fill_q != CW'(DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + CW'(1);
				2'b01:   fill_q <= fill_q - CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/adrs_front.sv =====
`default_nettype none
module adrs_front
	import adrs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic [S_TUSER_W-1:0] s_tuser,
	output logic                      cmd_valid,
	input  wire logic                 cmd_ready,
	output cmd_t                      cmd
);

	logic      valid_s1;
	cmd_t      cmd_s1;
	cmd_kind_t kind;

	// classify the opcode; the unused code becomes a no-op
	always_comb begin
		unique case (s_tuser)
			OP_PUSH_FRONT: kind = CMD_PUSH_FRONT;
			OP_PUSH_BACK:  kind = CMD_PUSH_BACK;
			OP_POP_FRONT:  kind = CMD_POP_FRONT;
			OP_POP_BACK:   kind = CMD_POP_BACK;
			OP_CLEAR:      kind = CMD_CLEAR;
			OP_REVERSE:    kind = CMD_REVERSE;
			OP_SORT:       kind = CMD_SORT;
			default:       kind = CMD_NOP;
		endcase
	end

	assign s_tready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.kind  <= kind;
			cmd_s1.value <= $signed(s_tdata[VALUE_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/adrs_back.sv =====
`default_nettype none
module adrs_back
	import adrs_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_pop,
	input  wire cmd_t                 cmd,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,
	output logic      [M_TUSER_W-1:0] m_tuser
);

	localparam int AW = $clog2(DEPTH);

	back_state_t state_q, state_d;

	logic [AW-1:0]             first_q, last_q;
	logic                      empty_q;
	logic [AW-1:0]             i_q, j_q;
	logic signed [VALUE_W-1:0] front_q, back_q, t_q;
	status_t                   status_q;

	logic                      we;
	logic [AW-1:0]             waddr, raddr;
	logic [VALUE_W-1:0]        wdata, rdata;

	logic                      res_valid_q;
	logic [M_TDATA_W-1:0]      tdata_q;
	logic [M_TUSER_W-1:0]      tuser_q;
	logic                      out_free;
	logic                      load_out;
	logic                      less;
	logic                      multi;
	logic [AW:0]               cnt_full;

	adrs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_free = !res_valid_q || m_tready;
	assign less     = t_q < $signed(rdata);
	assign multi    = !empty_q && (first_q < last_q);
	assign cnt_full = {1'b0, last_q} - {1'b0, first_q} + (AW + 1)'(1);
	assign m_tvalid = res_valid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_POP_FRONT, CMD_POP_BACK:
							state_d = multi ? BK_REF_A : BK_DONE;
						CMD_REVERSE: state_d = multi ? BK_REV_A : BK_DONE;
						CMD_SORT:    state_d = multi ? BK_SRT_LD : BK_DONE;
						default:     state_d = BK_DONE;
					endcase
				end
			end
			BK_REF_A:   state_d = BK_REF_B;
			BK_REF_B:   state_d = BK_REF_C;
			BK_REF_C:   state_d = BK_DONE;
			BK_REV_A:   state_d = BK_REV_B;
			BK_REV_B:   state_d = BK_REV_C;
			BK_REV_C:   state_d = BK_REV_D;
			BK_REV_D:   state_d = ((j_q - i_q) > AW'(2)) ? BK_REV_A : BK_REF_A;
			BK_SRT_LD:  state_d = BK_SRT_GET;
			BK_SRT_GET: state_d = BK_SRT_CMP;
			BK_SRT_CMP: begin
				if (!(less && ((j_q - AW'(1)) > first_q))) begin
					state_d = BK_SRT_PUT;
				end
			end
			BK_SRT_PUT: state_d = (i_q < last_q) ? BK_SRT_GET : BK_REF_A;
			BK_DONE:    state_d = out_free ? BK_IDLE : BK_DONE;
			default:    state_d = BK_IDLE;
		endcase
	end

	// store port, queue pop and result load
	always_comb begin
		we       = 1'b0;
		waddr    = '0;
		wdata    = cmd.value;
		raddr    = first_q;
		cmd_pop  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid && (cmd.kind == CMD_PUSH_FRONT)
						&& (empty_q || (first_q != '0))) begin
					we    = 1'b1;
					waddr = empty_q ? '0 : first_q - AW'(1);
				end
				if (cmd_valid && (cmd.kind == CMD_PUSH_BACK)
						&& (empty_q || (last_q != AW'(DEPTH - 1)))) begin
					we    = 1'b1;
					waddr = empty_q ? '0 : last_q + AW'(1);
				end
			end
			BK_REF_A:   raddr = first_q;
			BK_REF_B:   raddr = last_q;
			BK_REV_A:   raddr = i_q;
			BK_REV_B:   raddr = j_q;
			BK_REV_C: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rdata;
			end
			BK_REV_D: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = t_q;
			end
			BK_SRT_LD:  raddr = i_q;
			BK_SRT_GET: raddr = i_q - AW'(1);
			BK_SRT_CMP: begin
				raddr = j_q - AW'(2);
				if (less) begin
					we    = 1'b1;
					waddr = j_q;
					wdata = rdata;
				end
			end
			BK_SRT_PUT: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = t_q;
				raddr = i_q + AW'(1);
			end
			BK_DONE:    load_out = out_free;
			default:    raddr = first_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			first_q     <= '0;
			last_q      <= '0;
			empty_q     <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE && cmd_valid) begin
				unique case (cmd.kind)
					CMD_PUSH_FRONT: begin
						if (empty_q) begin
							first_q <= '0;
							last_q  <= '0;
							empty_q <= 1'b0;
						end else if (first_q != '0) begin
							first_q <= first_q - AW'(1);
						end
					end
					CMD_PUSH_BACK: begin
						if (empty_q) begin
							first_q <= '0;
							last_q  <= '0;
							empty_q <= 1'b0;
						end else if (last_q != AW'(DEPTH - 1)) begin
							last_q <= last_q + AW'(1);
						end
					end
					CMD_POP_FRONT: begin
						if (!empty_q) begin
							if (first_q >= last_q) begin
								first_q <= '0;
								last_q  <= '0;
								empty_q <= 1'b1;
							end else begin
								first_q <= first_q + AW'(1);
							end
						end
					end
					CMD_POP_BACK: begin
						if (!empty_q) begin
							if (last_q <= first_q) begin
								first_q <= '0;
								last_q  <= '0;
								empty_q <= 1'b1;
							end else begin
								last_q <= last_q - AW'(1);
							end
						end
					end
					CMD_CLEAR: begin
						first_q <= '0;
						last_q  <= '0;
						empty_q <= 1'b1;
					end
					default: begin
						empty_q <= empty_q;
					end
				endcase
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// working registers and the result word
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				// only a command actually taken from the queue may touch the cache
				if (cmd_valid) begin
					i_q <= (cmd.kind == CMD_SORT) ? first_q + AW'(1) : first_q;
					j_q <= last_q;
					unique case (cmd.kind)
						CMD_PUSH_FRONT: begin
							if (empty_q) begin
								status_q <= STS_OK;
								front_q  <= cmd.value;
								back_q   <= cmd.value;
							end else if (first_q != '0) begin
								status_q <= STS_OK;
								front_q  <= cmd.value;
							end else begin
								status_q <= STS_OVERFLOW;
							end
						end
						CMD_PUSH_BACK: begin
							if (empty_q) begin
								status_q <= STS_OK;
								front_q  <= cmd.value;
								back_q   <= cmd.value;
							end else if (last_q != AW'(DEPTH - 1)) begin
								status_q <= STS_OK;
								back_q   <= cmd.value;
							end else begin
								status_q <= STS_OVERFLOW;
							end
						end
						CMD_POP_FRONT, CMD_POP_BACK: begin
							status_q <= empty_q ? STS_UNDERFLOW : STS_OK;
						end
						default: begin
							status_q <= STS_OK;
						end
					endcase
				end
			end
			BK_REF_B:   front_q <= $signed(rdata);
			BK_REF_C:   back_q  <= $signed(rdata);
			BK_REV_B:   t_q     <= $signed(rdata);
			BK_REV_D: begin
				i_q <= i_q + AW'(1);
				j_q <= j_q - AW'(1);
			end
			BK_SRT_GET: begin
				t_q <= $signed(rdata);
				j_q <= i_q;
			end
			BK_SRT_CMP: begin
				if (less) begin
					j_q <= j_q - AW'(1);
				end
			end
			BK_SRT_PUT: i_q <= i_q + AW'(1);
			default: begin
				t_q <= t_q;
			end
		endcase
		if (load_out) begin
			if (empty_q) begin
				tdata_q <= {COUNT_W'(0), EMPTY_WORD, EMPTY_WORD};
			end else begin
				tdata_q <= {COUNT_W'(cnt_full), back_q, front_q};
			end
			tuser_q <= {empty_q, status_q};
		end
	end

endmodule
`default_nettype wire

// ===== hdl/array_deque_with_reverse_sort.sv =====
// Push, clear and no-op results pass the front stage, the command queue and the back-end
//   sequencer to m_tvalid; pops that leave words behind first reread both ends.
// The back-end sequencer carries out one command at a time: it takes it from the queue,
//   then loads its result. Reverse swaps one pair and insertion sort shifts one word at a
//   time, all on one store port.
// Reset: arst_n clears the queue, positions and handshakes; the deque comes up empty.
`default_nettype none
module array_deque_with_reverse_sort
	import adrs_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input words
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // value[31:0]
	input  wire logic [S_TUSER_W-1:0] s_tuser,   // opcode[2:0]
	// result words
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,   // front_value[31:0], back_value[63:32],
	                                             // count[71:64]
	output logic      [M_TUSER_W-1:0] m_tuser    // status[1:0], is_empty[2]
);

	// Front end: take a word, classify the opcode into a command and hold it
	// in a one-deep stage until the queue takes it.
	cmd_t fr_cmd;
	logic fr_valid;
	logic fr_ready;

	// Back end side of the queue.
	cmd_t bk_cmd;
	logic bk_valid;
	logic bk_pop;

	adrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_valid(fr_valid),
		.cmd_ready(fr_ready),
		.cmd      (fr_cmd)
	);

	// Short command queue: the front keeps accepting while the back end
	// walks the store for a reverse or a sort, or waits on m_tready.
	adrs_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.in_data  (fr_cmd),
		.out_valid(bk_valid),
		.out_ready(bk_pop),
		.out_data (bk_cmd)
	);

	// Back end: owns the word store and both positions, carries out one
	// command at a time and drives the result register. Front and back words
	// are cached so pushes need no store read; pops, reverse and sort reread
	// both ends from the store when they finish.
	adrs_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(bk_valid),
		.cmd_pop  (bk_pop),
		.cmd      (bk_cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== hdl/adrs_checker.sv =====
`default_nettype none
`include "array_deque_with_reverse_sort_defines.svh"
module adrs_checker
	import adrs_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser
);

	// hold a stalled result
	`ADRS_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// an empty deque reports the empty marker at both ends and no words
	`ADRS_ASSERT_NOW(a_empty_fields, clk, arst_n, m_tvalid && m_tuser[2], (m_tdata[31:0] == 32'hFFFF_FFFF) && (m_tdata[63:32] == 32'hFFFF_FFFF) && (m_tdata[71:64] == 8'd0))

	// underflow leaves the deque empty
	`ADRS_ASSERT_NOW(a_underflow_empty, clk, arst_n, m_tvalid && (m_tuser[1:0] == STS_UNDERFLOW), m_tuser[2])

	// overflow only happens with words held
	`ADRS_ASSERT_NOW(a_overflow_held, clk, arst_n, m_tvalid && (m_tuser[1:0] == STS_OVERFLOW), !m_tuser[2])

endmodule

bind array_deque_with_reverse_sort adrs_checker u_adrs_checker (.*);
`default_nettype wire

// ===== dv/deque_checker.sv =====
// Watches both stream channels of the deque, keeps its own copy of the
// store and predicts one result word per accepted command word.
module deque_checker
	import adrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // value[31:0]
	input  logic [S_TUSER_W-1:0] s_tuser,   // opcode[2:0]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // front_value[31:0], back_value[63:32],
	                                        // count[71:64]
	input  logic [M_TUSER_W-1:0] m_tuser,   // status[1:0], is_empty[2]
	output int                   fail_count,
	output int                   pending,
	output int                   results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t             sts;
		logic [VALUE_W-1:0]  front;
		logic [VALUE_W-1:0]  back;
		logic [COUNT_W-1:0]  cnt;
		logic                vacant;
	} deque_view_t;

	logic [VALUE_W-1:0] word_mem [DEPTH_DEF];
	int                 head_pos;
	int                 tail_pos;
	bit                 vacant;
	deque_view_t        views [$];

	function automatic void empty_deque();
		head_pos = 0;
		tail_pos = 0;
		vacant   = 1'b1;
	endfunction

	function automatic void seat_first(logic [VALUE_W-1:0] val);
		head_pos    = 0;
		tail_pos    = 0;
		vacant      = 1'b0;
		word_mem[0] = val;
	endfunction

	function automatic deque_view_t step_deque(logic [OPCODE_W-1:0] op,
			logic [VALUE_W-1:0] val);
		deque_view_t        view;
		int                 i;
		int                 j;
		logic [VALUE_W-1:0] t;
		view.sts = STS_OK;
		case (op)
			OP_PUSH_FRONT: begin
				if (vacant) seat_first(val);
				else if (head_pos > 0) begin
					head_pos--;
					word_mem[head_pos] = val;
				end else view.sts = STS_OVERFLOW;
			end
			OP_PUSH_BACK: begin
				if (vacant) seat_first(val);
				else if (tail_pos >= DEPTH_DEF - 1) view.sts = STS_OVERFLOW;
				else begin
					tail_pos++;
					word_mem[tail_pos] = val;
				end
			end
			OP_POP_FRONT: begin
				if (vacant) view.sts = STS_UNDERFLOW;
				else if (head_pos >= tail_pos) empty_deque();
				else head_pos++;
			end
			OP_POP_BACK: begin
				if (vacant) view.sts = STS_UNDERFLOW;
				else if (tail_pos <= head_pos) empty_deque();
				else tail_pos--;
			end
			OP_CLEAR: empty_deque();
			OP_REVERSE: begin
				i = head_pos;
				j = tail_pos;
				while (!vacant && i < j) begin
					t           = word_mem[i];
					word_mem[i] = word_mem[j];
					word_mem[j] = t;
					i++;
					j--;
				end
			end
			OP_SORT: begin
				// insertion sort, ascending signed
				for (i = head_pos + 1; !vacant && i <= tail_pos; i++) begin
					t = word_mem[i];
					j = i;
					while (j > head_pos && $signed(t) < $signed(word_mem[j-1])) begin
						word_mem[j] = word_mem[j-1];
						j--;
					end
					word_mem[j] = t;
				end
			end
			default: ;
		endcase
		view.vacant = vacant;
		if (vacant) begin
			view.front = EMPTY_WORD;
			view.back  = EMPTY_WORD;
			view.cnt   = '0;
		end else begin
			view.front = word_mem[head_pos];
			view.back  = word_mem[tail_pos];
			view.cnt   = COUNT_W'(tail_pos - head_pos + 1);
		end
		return view;
	endfunction

	function automatic void check_field(string tag, logic [VALUE_W-1:0] want_v,
			logic [VALUE_W-1:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, tag, want_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		deque_view_t want;
		if (!arst_n) begin
			empty_deque();
			views.delete();
			fail_count   = 0;
			pending      = 0;
			results_seen = 0;
		end else begin
			// retire the result word first; it belongs to an older command
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (views.size() == 0) begin
					fail_count++;
					$display("%0t ns: result word with nothing predicted, expected none, actual %h/%h",
						$time, m_tuser, m_tdata);
				end else begin
					want = views[0];
					views.delete(0);
					check_field("status", VALUE_W'(want.sts), VALUE_W'(m_tuser[1:0]));
					check_field("front_value", want.front, m_tdata[31:0]);
					check_field("back_value", want.back, m_tdata[63:32]);
					check_field("count", VALUE_W'(want.cnt), VALUE_W'(m_tdata[71:64]));
					check_field("is_empty", VALUE_W'(want.vacant), VALUE_W'(m_tuser[2]));
				end
			end
			if (s_tvalid && s_tready)
				views.insert(views.size(), step_deque(s_tuser, s_tdata));
			pending = views.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Top of the deque bench: clock, reset, command stimulus and receiver stalls.
// All prediction and comparison lives in deque_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import adrs_pkg::*;

	// the block decodes opcode 7 as a no-op
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
	localparam int ITEM_TARGET = 1875;
	localparam int STALL_PCT   = 27;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // value[31:0]
	logic [S_TUSER_W-1:0] s_tuser;   // opcode[2:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // front_value[31:0], back_value[63:32], count[71:64]
	logic [M_TUSER_W-1:0] m_tuser;   // status[1:0], is_empty[2]

	int fail_count;
	int pending;
	int results_seen;

	// calm turns off idling on both sides for one long stretch
	bit calm;
	bit did_big;
	int items_sent;
	int reverses_sent;
	int sorts_sent;
	int big_fills;

	array_deque_with_reverse_sort dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	deque_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: drop tready at random except in the calm stretch.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
		end
	end

	// Hard stop well past the slowest legal run, even if every sort met a
	// reversed, nearly full deque.
	initial begin
		#200_000_000;
		$display("timeout with %0d result words still outstanding", pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Mix of boundary words, small values that make sort see duplicates, and noise.
	function automatic logic [VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			4:       return VALUE_W'($urandom_range(0, 15));
			5:       return -VALUE_W'($urandom_range(1, 15));
			default: return $urandom;
		endcase
	endfunction

	// Entered and left at a falling edge. Tvalid stays high into the next word
	// unless the next call idles first.
	task automatic send_cmd(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val);
		if (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (op != OP_UNUSED) items_sent++;
		if (op == OP_REVERSE) reverses_sent++;
		if (op == OP_SORT) sorts_sent++;
	endtask

	// Hold off the sender until every predicted result word has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// Random walk over all operations; pushes slightly favored so the deque grows.
	task automatic mixed_run();
		int pick;
		repeat ($urandom_range(10, 40)) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) send_cmd(OP_PUSH_BACK, pick_word());
			else if (pick < 45) send_cmd(OP_PUSH_FRONT, pick_word());
			else if (pick < 60) send_cmd(OP_POP_FRONT, $urandom);
			else if (pick < 75) send_cmd(OP_POP_BACK, $urandom);
			else if (pick < 78) send_cmd(OP_CLEAR, $urandom);
			else if (pick < 86) send_cmd(OP_REVERSE, $urandom);
			else if (pick < 94) send_cmd(OP_SORT, $urandom);
			else send_cmd(OP_UNUSED, $urandom);
		end
	endtask

	// Well-formed fill: clear, load from the back, open room at the front and
	// refill it past the edge, then reorder and drain from the back.
	task automatic fill_run();
		int  k;
		int  j;
		bit  big;
		big = !did_big || ($urandom_range(0, 9) == 0);
		k   = big ? $urandom_range(DEPTH_DEF - 8, DEPTH_DEF + 2) : $urandom_range(1, 16);
		if (big) begin
			did_big = 1'b1;
			big_fills++;
		end
		send_cmd(OP_CLEAR, $urandom);
		repeat (k) send_cmd(OP_PUSH_BACK, pick_word());
		j = $urandom_range(0, k);
		repeat (j) send_cmd(OP_POP_FRONT, $urandom);
		repeat ($urandom_range(0, j + 2)) send_cmd(OP_PUSH_FRONT, pick_word());
		if ($urandom_range(0, 1)) send_cmd(OP_REVERSE, $urandom);
		if ($urandom_range(0, 2) != 0) send_cmd(OP_SORT, $urandom);
		if ($urandom_range(0, 1)) send_cmd(OP_REVERSE, $urandom);
		repeat ($urandom_range(0, big ? 6 : k + 1)) send_cmd(OP_POP_BACK, $urandom);
	endtask

	// Raw noise on every opcode, unused one included.
	task automatic noise_run();
		repeat ($urandom_range(4, 16))
			send_cmd(OPCODE_W'($urandom_range(0, 7)), $urandom);
	endtask

	initial begin : stimulus
		bit paused_mid;
		int pick;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		arst_n        = 1'b0;
		calm          = 1'b0;
		did_big       = 1'b0;
		paused_mid    = 1'b0;
		items_sent    = 0;
		reverses_sent = 0;
		sorts_sent    = 0;
		big_fills     = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty deque: pops underflow, clear/reverse/sort/no-op change nothing
		send_cmd(OP_POP_FRONT, 32'h1234_5678);
		send_cmd(OP_POP_BACK, 32'h8765_4321);
		send_cmd(OP_CLEAR, 32'hffff_ffff);
		send_cmd(OP_REVERSE, 32'h0);
		send_cmd(OP_SORT, 32'h0);
		send_cmd(OP_UNUSED, 32'hffff_ffff);
		// push front onto empty lands at position 0, so the next one overflows
		send_cmd(OP_PUSH_FRONT, 32'h8000_0000);
		send_cmd(OP_PUSH_FRONT, 32'h7fff_ffff);
		send_cmd(OP_PUSH_BACK, 32'h7fff_ffff);
		send_cmd(OP_PUSH_BACK, 32'hffff_ffff);
		send_cmd(OP_PUSH_BACK, 32'h0000_0000);
		send_cmd(OP_PUSH_BACK, 32'h0000_0001);
		send_cmd(OP_PUSH_BACK, 32'h8000_0000);
		send_cmd(OP_REVERSE, 32'h0);
		send_cmd(OP_SORT, 32'h0);
		// a pop at the front opens one slot there
		send_cmd(OP_POP_FRONT, 32'h0);
		send_cmd(OP_PUSH_FRONT, 32'h0000_0005);
		send_cmd(OP_PUSH_FRONT, 32'hdead_beef);
		send_cmd(OP_UNUSED, 32'h0);
		// drain from the back; the last pop returns both positions to zero
		repeat (5) send_cmd(OP_POP_BACK, 32'h0);
		send_cmd(OP_POP_BACK, 32'h0);
		drain();

		while (items_sent < ITEM_TARGET) begin
			calm = (items_sent >= 700 && items_sent < 1000);
			if (!paused_mid && items_sent >= 1200) begin
				drain();
				paused_mid = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) mixed_run();
			else if (pick < 85) fill_run();
			else noise_run();
		end
		calm = 1'b0;

		drain();
		// let a late pop-reread result or a spurious word show up
		repeat (24) @(posedge clk);
		$display("covered %0d command words (%0d reverse, %0d sort, %0d near-full fills)",
			items_sent, reverses_sent, sorts_sent, big_fills);
		$display("checked %0d result words field by field, %0d failures",
			results_seen, fail_count);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/adrs_pkg.sv
hdl/adrs_ram.sv
hdl/adrs_fifo.sv
hdl/adrs_front.sv
hdl/adrs_back.sv
hdl/array_deque_with_reverse_sort.sv
hdl/adrs_checker.sv
dv/deque_checker.sv
dv/tb.sv
